/* rtl/core/assert_macros.svh */
// assertion macros shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// expr must hold at every clock edge out of reset
`define SPC_ASSERT(lbl, clk, rst_n, expr) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
		else $error("assertion failed");
// cons must hold in the same cycle as ante
`define SPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("assertion failed");
// cons must hold in the cycle after ante
`define SPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("assertion failed");
`else
`define SPC_ASSERT(lbl, clk, rst_n, expr)
`define SPC_ASSERT_IMPL(lbl, clk, rst_n, ante, cons)
`define SPC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons)
`endif
`endif

/* rtl/core/spc_pkg.sv */
package spc_pkg;

	localparam int COORD_BITS = 12;
	localparam int DIM_W      = 11;
	localparam int PIX_W      = 11;
	localparam int RAD_W      = 10;
	localparam int ABS_W      = RAD_W + 1;
	localparam int SQ_W       = 2 * ABS_W;
	localparam int RSQ_W      = 2 * RAD_W;
	// rotated coordinate width: covers dim minus (anchor + far)
	localparam int RW = ((COORD_BITS + 1 > DIM_W + 1) ? COORD_BITS + 1 : DIM_W + 1) + 1;

	// shape kinds
	localparam logic [1:0] CMD_POINT  = 2'd0;
	localparam logic [1:0] CMD_LINE   = 2'd1;
	localparam logic [1:0] CMD_RECT   = 2'd2;
	localparam logic [1:0] CMD_CIRCLE = 2'd3;

	// orientation codes
	localparam logic [1:0] ROT_NONE    = 2'd0;
	localparam logic [1:0] ROT_QUARTER = 2'd1;
	localparam logic [1:0] ROT_HALF    = 2'd2;
	localparam logic [1:0] ROT_3QUART  = 2'd3;

	// configuration register indexes
	localparam logic [1:0] CFG_ORIENTATION = 2'd0;
	localparam logic [1:0] CFG_DISP_WIDTH  = 2'd1;
	localparam logic [1:0] CFG_DISP_HEIGHT = 2'd2;

	localparam logic [1:0]       ORIENT_RST = ROT_NONE;
	localparam logic [DIM_W-1:0] WIDTH_RST  = 11'd296;
	localparam logic [DIM_W-1:0] HEIGHT_RST = 11'd128;

	typedef struct packed {
		logic [1:0]                   command;
		logic                         fill;
		logic signed [COORD_BITS-1:0] anchor_x;
		logic signed [COORD_BITS-1:0] anchor_y;
		logic signed [COORD_BITS-1:0] far_x;
		logic signed [COORD_BITS-1:0] far_y;
		logic [RAD_W-1:0]             radius;
		logic [PIX_W-1:0]             pixel_x;
		logic [PIX_W-1:0]             pixel_y;
		logic [7:0]                   in_byte;
	} pix_item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		logic       covered;
	} res_item_t;

	typedef struct packed {
		logic signed [RW-1:0] x;
		logic signed [RW-1:0] y;
	} pt_t;

	// circle operands handed to the squaring stage
	typedef struct packed {
		logic             near;
		logic             fill;
		logic [RAD_W-1:0] radius;
		logic [ABS_W-1:0] adx;
		logic [ABS_W-1:0] ady;
	} circ_op_t;

	function automatic pt_t rotate(input logic [1:0] orient, input logic signed [RW-1:0] sx,
		input logic signed [RW-1:0] sy, input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		pt_t p;
		logic signed [RW-1:0] wv;
		logic signed [RW-1:0] hv;
		wv = $signed({{(RW-DIM_W){1'b0}}, w});
		hv = $signed({{(RW-DIM_W){1'b0}}, h});
		unique case (orient)
			ROT_NONE: begin
				p.x = sx;
				p.y = sy;
			end
			ROT_QUARTER: begin
				p.x = wv - sy;
				p.y = sx;
			end
			ROT_HALF: begin
				p.x = wv - sx;
				p.y = hv - sy;
			end
			ROT_3QUART: begin
				p.x = sy;
				p.y = hv - sx;
			end
			default: begin
				p.x = sx;
				p.y = sy;
			end
		endcase
		return p;
	endfunction

endpackage

/* rtl/core/spc_circle.sv */
module spc_circle (
	input  logic              clk,
	input  logic              ld,
	input  spc_pkg::circ_op_t op,
	output logic              hit
);

	logic [spc_pkg::SQ_W-1:0]  sqx_s4;
	logic [spc_pkg::SQ_W-1:0]  sqy_s4;
	logic [spc_pkg::RSQ_W-1:0] rsq_s4;
	logic [spc_pkg::RAD_W-1:0] r_s4;
	logic                      fill_s4;
	logic                      near_s4;

	logic [spc_pkg::SQ_W:0] d;
	logic [spc_pkg::SQ_W:0] rsq_e;
	logic [spc_pkg::SQ_W:0] r_e;
	logic [spc_pkg::SQ_W:0] rsq_hi;
	logic [spc_pkg::SQ_W:0] rsq_lo;
	logic                   ring;

	// squares of the offsets and of the radius
	always_ff @(posedge clk) begin
		if (ld) begin
			sqx_s4  <= op.adx * op.adx;
			sqy_s4  <= op.ady * op.ady;
			rsq_s4  <= op.radius * op.radius;
			r_s4    <= op.radius;
			fill_s4 <= op.fill;
			near_s4 <= op.near;
		end
	end

	assign d      = {1'b0, sqx_s4} + {1'b0, sqy_s4};
	assign rsq_e  = {{(spc_pkg::SQ_W + 1 - spc_pkg::RSQ_W){1'b0}}, rsq_s4};
	assign r_e    = {{(spc_pkg::SQ_W + 1 - spc_pkg::RAD_W){1'b0}}, r_s4};
	assign rsq_hi = rsq_e + r_e;
	assign rsq_lo = rsq_e - r_e;

	// rounded distance equals r: r*r - r < d <= r*r + r, zero radius only the centre
	assign ring = (d <= rsq_hi) && ((r_s4 == '0) || (d > rsq_lo));
	assign hit  = near_s4 && (fill_s4 ? (d <= rsq_e) : ring);

endmodule

/* rtl/core/shape_pixel_coverage_top.sv */
// shape pixel coverage: tests one pixel of a 1-bit-per-pixel frame against one shape
// (point, horizontal or vertical line, filled or outlined rectangle, filled or
// outlined circle) and clears the pixel's bit, bit 7-(pixel_x mod 8), in the frame
// byte when the shape covers it. shape coordinates are rotated by the orientation
// register using disp_width and disp_height as mirror terms; line ends and rectangle
// corners are ordered after rotation. a circle outline is the ring where the rounded
// distance from the centre equals the radius. throughput is one pixel per clock while
// the receiver takes every result. stages: input register, rotation, edge and offset
// tests, squaring, result register. the squaring multipliers set the stage split.
// ready falls only when the result register holds an untaken result and every stage
// is full. config writes are taken at any time with cfg_ready held high, but take
// effect on items already inside the pipe, so write only while the block is empty.
`include "assert_macros.svh"

module shape_pixel_coverage_top (
	input  logic                       clk,
	input  logic                       arst_n,
	// pixel and shape in
	input  logic                       pix_valid,
	output logic                       pix_ready,
	input  spc_pkg::pix_item_t         pix,
	// coverage result out
	output logic                       res_valid,
	input  logic                       res_ready,
	output spc_pkg::res_item_t         res,
	// register writes
	input  logic                       cfg_valid,
	output logic                       cfg_ready,
	input  logic [1:0]                 cfg_index,
	input  logic [spc_pkg::DIM_W-1:0]  cfg_data
);

	localparam int RW = spc_pkg::RW;

	// configuration registers
	logic [1:0]                orient_q;
	logic [spc_pkg::DIM_W-1:0] width_q;
	logic [spc_pkg::DIM_W-1:0] height_q;

	// stage valids and per-stage ready
	logic v_s1, v_s2, v_s3, v_s4, res_valid_q;
	logic rdy_s1, rdy_s2, rdy_s3, rdy_s4, rdy_out;

	// stage 1: input register
	spc_pkg::pix_item_t pix_s1;

	// stage 2: rotated points
	logic [1:0]                cmd_s2;
	logic                      fill_s2;
	logic [spc_pkg::RAD_W-1:0] r_s2;
	logic [spc_pkg::PIX_W-1:0] px_s2;
	logic [spc_pkg::PIX_W-1:0] py_s2;
	logic [7:0]                byte_s2;
	spc_pkg::pt_t              p0_s2;
	spc_pkg::pt_t              p1_s2;

	// stage 3: geometry result and circle offsets
	logic              geom_s3;
	logic              circ_s3;
	logic [2:0]        bit_s3;
	logic [7:0]        byte_s3;
	spc_pkg::circ_op_t cop_s3;

	// stage 4: payload alongside the squares
	logic       geom_s4;
	logic       circ_s4;
	logic [2:0] bit_s4;
	logic [7:0] byte_s4;
	logic       circ_hit;

	spc_pkg::res_item_t res_q;

	// ---------------------------------------------------------------
	// handshake: a stage loads when empty or when its content moves on
	// ---------------------------------------------------------------
	assign rdy_out   = !res_valid_q || res_ready;
	assign rdy_s4    = !v_s4 || rdy_out;
	assign rdy_s3    = !v_s3 || rdy_s4;
	assign rdy_s2    = !v_s2 || rdy_s3;
	assign rdy_s1    = !v_s1 || rdy_s2;
	assign pix_ready = rdy_s1;
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1        <= 1'b0;
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (rdy_s1) v_s1 <= pix_valid;
			if (rdy_s2) v_s2 <= v_s1;
			if (rdy_s3) v_s3 <= v_s2;
			if (rdy_s4) v_s4 <= v_s3;
			if (rdy_out) res_valid_q <= v_s4;
		end
	end

	// ---------------------------------------------------------------
	// configuration transfer, indexes past the list are dropped
	// ---------------------------------------------------------------
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			orient_q <= spc_pkg::ORIENT_RST;
			width_q  <= spc_pkg::WIDTH_RST;
			height_q <= spc_pkg::HEIGHT_RST;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				spc_pkg::CFG_ORIENTATION: orient_q <= cfg_data[1:0];
				spc_pkg::CFG_DISP_WIDTH:  width_q  <= cfg_data;
				spc_pkg::CFG_DISP_HEIGHT: height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// ---------------------------------------------------------------
	// stage 1: input register
	// ---------------------------------------------------------------
	always_ff @(posedge clk) begin
		if (rdy_s1) pix_s1 <= pix;
	end

	// ---------------------------------------------------------------
	// stage 2: rotate the anchor and the far point
	// ---------------------------------------------------------------
	logic signed [RW-1:0] ax_e, ay_e, fx_e, fy_e, ex, ey;

	assign ax_e = RW'(pix_s1.anchor_x);
	assign ay_e = RW'(pix_s1.anchor_y);
	assign fx_e = RW'(pix_s1.far_x);
	assign fy_e = RW'(pix_s1.far_y);
	// a line carries its end point, a rectangle its size
	assign ex = (pix_s1.command == spc_pkg::CMD_LINE) ? fx_e : ax_e + fx_e;
	assign ey = (pix_s1.command == spc_pkg::CMD_LINE) ? fy_e : ay_e + fy_e;

	always_ff @(posedge clk) begin
		if (rdy_s2) begin
			cmd_s2  <= pix_s1.command;
			fill_s2 <= pix_s1.fill;
			r_s2    <= pix_s1.radius;
			px_s2   <= pix_s1.pixel_x;
			py_s2   <= pix_s1.pixel_y;
			byte_s2 <= pix_s1.in_byte;
			p0_s2   <= spc_pkg::rotate(orient_q, ax_e, ay_e, width_q, height_q);
			p1_s2   <= spc_pkg::rotate(orient_q, ex, ey, width_q, height_q);
		end
	end

	// ---------------------------------------------------------------
	// stage 3: ordered bounds, edge tests, circle offsets
	// ---------------------------------------------------------------
	logic signed [RW-1:0] pxs, pys, lx, hx, ly, hy;
	logic signed [RW:0]   dx, dy;
	logic [RW:0]          adx, ady;
	logic [RW:0]          rp1;
	logic                 inx, iny, hit_point, hit_line, hit_rect, geom;

	assign pxs = $signed({{(RW - spc_pkg::PIX_W){1'b0}}, px_s2});
	assign pys = $signed({{(RW - spc_pkg::PIX_W){1'b0}}, py_s2});

	assign lx = (p0_s2.x < p1_s2.x) ? p0_s2.x : p1_s2.x;
	assign hx = (p0_s2.x < p1_s2.x) ? p1_s2.x : p0_s2.x;
	assign ly = (p0_s2.y < p1_s2.y) ? p0_s2.y : p1_s2.y;
	assign hy = (p0_s2.y < p1_s2.y) ? p1_s2.y : p0_s2.y;

	assign inx = (pxs >= lx) && (pxs <= hx);
	assign iny = (pys >= ly) && (pys <= hy);

	assign hit_point = (p0_s2.x == pxs) && (p0_s2.y == pys);
	// horizontal on this row, or vertical on this column
	assign hit_line = ((p0_s2.y == p1_s2.y) && (p0_s2.y == pys) && inx) ||
		((p0_s2.x == p1_s2.x) && (p0_s2.x == pxs) && iny);
	assign hit_rect = fill_s2 ? (inx && iny) :
		(((pxs == lx) || (pxs == hx)) && iny) || (((pys == ly) || (pys == hy)) && inx);

	always_comb begin
		unique case (cmd_s2)
			spc_pkg::CMD_POINT: geom = hit_point;
			spc_pkg::CMD_LINE:  geom = hit_line;
			spc_pkg::CMD_RECT:  geom = hit_rect;
			default:            geom = 1'b0;
		endcase
	end

	// offsets from the centre, one bit wider to hold the full span
	assign dx  = $signed({pxs[RW-1], pxs}) - $signed({p0_s2.x[RW-1], p0_s2.x});
	assign dy  = $signed({pys[RW-1], pys}) - $signed({p0_s2.y[RW-1], p0_s2.y});
	assign adx = dx[RW] ? (~dx + 1'b1) : dx;
	assign ady = dy[RW] ? (~dy + 1'b1) : dy;
	assign rp1 = {{(RW + 1 - spc_pkg::RAD_W){1'b0}}, r_s2} + 1'b1;

	always_ff @(posedge clk) begin
		if (rdy_s3) begin
			geom_s3        <= geom;
			circ_s3        <= (cmd_s2 == spc_pkg::CMD_CIRCLE);
			bit_s3         <= px_s2[2:0];
			byte_s3        <= byte_s2;
			// inside the box of side 2r+3 the offsets fit the narrow squarers
			cop_s3.near    <= (adx <= rp1) && (ady <= rp1);
			cop_s3.fill    <= fill_s2;
			cop_s3.radius  <= r_s2;
			cop_s3.adx     <= adx[spc_pkg::ABS_W-1:0];
			cop_s3.ady     <= ady[spc_pkg::ABS_W-1:0];
		end
	end

	// ---------------------------------------------------------------
	// stage 4: squares, circle decision
	// ---------------------------------------------------------------
	spc_circle u_circle (
		.clk (clk),
		.ld  (rdy_s4),
		.op  (cop_s3),
		.hit (circ_hit)
	);

	always_ff @(posedge clk) begin
		if (rdy_s4) begin
			geom_s4 <= geom_s3;
			circ_s4 <= circ_s3;
			bit_s4  <= bit_s3;
			byte_s4 <= byte_s3;
		end
	end

	// ---------------------------------------------------------------
	// result register: clear the pixel bit on coverage
	// ---------------------------------------------------------------
	logic       cov;
	logic [7:0] mask;

	assign cov  = circ_s4 ? circ_hit : geom_s4;
	assign mask = 8'h80 >> bit_s4;

	always_ff @(posedge clk) begin
		if (rdy_out) begin
			res_q.covered  <= cov;
			res_q.out_byte <= cov ? (byte_s4 & ~mask) : byte_s4;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

	// ---------------------------------------------------------------
	// checks
	// ---------------------------------------------------------------
	logic ld_out;
	assign ld_out = rdy_out && v_s4;

	// result never sets a bit of the frame byte
	`SPC_ASSERT_NEXT(a_no_set_bits, clk, arst_n, ld_out, (res.out_byte & ~$past(byte_s4)) == 8'h00)
	// at most one bit is cleared, and only on coverage
	`SPC_ASSERT_NEXT(a_one_bit, clk, arst_n, ld_out, $countones(res.out_byte ^ $past(byte_s4)) <= 1)
	`SPC_ASSERT_NEXT(a_clear_needs_cov, clk, arst_n, ld_out, (res.out_byte == $past(byte_s4)) || res.covered)
	// a stalled stage keeps its contents
	`SPC_ASSERT_NEXT(a_s3_hold, clk, arst_n, v_s3 && !rdy_s4, v_s3 && $stable(byte_s3) && $stable(geom_s3))
	`SPC_ASSERT_NEXT(a_s2_hold, clk, arst_n, v_s2 && !rdy_s3, v_s2 && $stable(p0_s2) && $stable(p1_s2))

endmodule

/* verif/shape_pixel_coverage_check.sv */
module shape_pixel_coverage_check
	import spc_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               pix_valid,
	input  logic               pix_ready,
	input  pix_item_t          pix,
	input  logic               res_valid,
	input  logic               res_ready,
	input  res_item_t          res,
	input  logic               cfg_valid,
	input  logic               cfg_ready,
	input  logic [1:0]         cfg_index,
	input  logic [DIM_W-1:0]   cfg_data,
	output int                 errors,
	output int                 pending,
	output int                 results_seen,
	output int                 covered_seen
);

	typedef struct {
		longint x;
		longint y;
	} spot_t;

	logic [1:0]       orient_q = ORIENT_RST;
	logic [DIM_W-1:0] width_q  = WIDTH_RST;
	logic [DIM_W-1:0] height_q = HEIGHT_RST;

	// predicted frame bytes, oldest first
	res_item_t coverage_due[$];

	function automatic spot_t turn(input longint sx, input longint sy);
		spot_t  p;
		longint w;
		longint h;
		w = width_q;
		h = height_q;
		case (orient_q)
			ROT_QUARTER: begin
				p.x = w - sy;
				p.y = sx;
			end
			ROT_HALF: begin
				p.x = w - sx;
				p.y = h - sy;
			end
			ROT_3QUART: begin
				p.x = sy;
				p.y = h - sx;
			end
			default: begin
				p.x = sx;
				p.y = sy;
			end
		endcase
		return p;
	endfunction

	function automatic bit shape_hits_pixel(input pix_item_t it);
		spot_t  c0;
		spot_t  c1;
		longint ax, ay, fx, fy, px, py, r;
		longint lx, hx, ly, hy, dx, dy, d, ring_hi, ring_lo;
		bit     inx, iny, hit;
		ax = $signed(it.anchor_x);
		ay = $signed(it.anchor_y);
		fx = $signed(it.far_x);
		fy = $signed(it.far_y);
		px = it.pixel_x;
		py = it.pixel_y;
		r  = it.radius;
		hit = 1'b0;
		c0 = turn(ax, ay);
		case (it.command)
			CMD_POINT: begin
				hit = (c0.x == px) && (c0.y == py);
			end
			CMD_LINE, CMD_RECT: begin
				if (it.command == CMD_LINE)
					c1 = turn(fx, fy);
				else
					c1 = turn(ax + fx, ay + fy);
				lx = (c0.x < c1.x) ? c0.x : c1.x;
				hx = (c0.x > c1.x) ? c0.x : c1.x;
				ly = (c0.y < c1.y) ? c0.y : c1.y;
				hy = (c0.y > c1.y) ? c0.y : c1.y;
				inx = (px >= lx) && (px <= hx);
				iny = (py >= ly) && (py <= hy);
				if (it.command == CMD_LINE) begin
					// only horizontal and vertical lines draw anything
					hit = (c0.y == c1.y && c0.y == py && inx) ||
						(c0.x == c1.x && c0.x == px && iny);
				end else if (it.fill) begin
					hit = inx && iny;
				end else begin
					hit = ((px == lx || px == hx) && iny) || ((py == ly || py == hy) && inx);
				end
			end
			default: begin
				dx = px - c0.x;
				dy = py - c0.y;
				if (dx < 0)
					dx = -dx;
				if (dy < 0)
					dy = -dy;
				if (dx <= r + 1 && dy <= r + 1) begin
					d = dx * dx + dy * dy;
					ring_hi = 2 * r + 1;
					ring_lo = 2 * r - 1;
					if (it.fill)
						hit = d <= r * r;
					else
						hit = (4 * d < ring_hi * ring_hi) && (r == 0 || ring_lo * ring_lo <= 4 * d);
				end
			end
		endcase
		return hit;
	endfunction

	function automatic res_item_t cleared_byte(input pix_item_t it);
		res_item_t o;
		o.covered  = shape_hits_pixel(it);
		o.out_byte = it.in_byte;
		if (o.covered)
			o.out_byte[7 - it.pixel_x[2:0]] = 1'b0;
		return o;
	endfunction

	always @(posedge clk) begin
		res_item_t want;
		if (!arst_n) begin
			orient_q = ORIENT_RST;
			width_q  = WIDTH_RST;
			height_q = HEIGHT_RST;
			coverage_due.delete();
		end else begin
			// result side first so a result never meets the item entering this cycle
			if (res_valid && res_ready) begin
				results_seen++;
				if (res.covered)
					covered_seen++;
				if (coverage_due.size() == 0) begin
					if (errors < 10)
						$display("%0t: result %02h/%0b with no pixel outstanding",
							$time, res.out_byte, res.covered);
					errors++;
				end else begin
					want = coverage_due.pop_front();
					if (res.out_byte !== want.out_byte || res.covered !== want.covered) begin
						if (errors < 10)
							$display("%0t: out_byte %02h covered %0b, expected %02h %0b",
								$time, res.out_byte, res.covered, want.out_byte, want.covered);
						errors++;
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_ORIENTATION: orient_q = cfg_data[1:0];
					CFG_DISP_WIDTH:  width_q  = cfg_data;
					CFG_DISP_HEIGHT: height_q = cfg_data;
					default: ;
				endcase
			end
			if (pix_valid && pix_ready)
				coverage_due.push_back(cleared_byte(pix));
		end
		pending = coverage_due.size();
	end

endmodule

/* verif/shape_pixel_coverage_top_tb.sv */
module shape_pixel_coverage_top_tb;
	import spc_pkg::*;

	localparam int RESET_CYCLES = 11;
	// receiver hold-off long enough to fill all five stages and stall the input
	localparam int HOLD_CYCLES  = 300;
	// cycles without any transfer before the run is declared hung
	localparam int STALL_LIMIT  = 4000;
	localparam int PHASE_ITEMS  = 120;
	localparam int NUM_PHASES   = 8;
	// pipe depth is five, leave some margin at the end
	localparam int DRAIN_CYCLES = 10;
	// register index past the last real register, must be ignored
	localparam logic [1:0] CFG_SPARE = 2'd3;

	typedef struct {
		int x;
		int y;
	} xy_t;

	logic             clk;
	logic             arst_n;
	logic             pix_valid;
	logic             pix_ready;
	pix_item_t        pix;
	logic             res_valid;
	logic             res_ready;
	res_item_t        res;
	logic             cfg_valid;
	logic             cfg_ready;
	logic [1:0]       cfg_index;
	logic [DIM_W-1:0] cfg_data;

	int errors;
	int pending;
	int results_seen;
	int covered_seen;

	// stimulus state: what has been written, and the idling knobs
	logic [1:0] orient_cfg;
	int         width_cfg;
	int         height_cfg;
	bit         quiet;
	bit         hold_req;
	int         n_sent;
	int         settings_run;

	shape_pixel_coverage_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res       (res),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	shape_pixel_coverage_check chk (
		.clk          (clk),
		.arst_n       (arst_n),
		.pix_valid    (pix_valid),
		.pix_ready    (pix_ready),
		.pix          (pix),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res          (res),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.errors       (errors),
		.pending      (pending),
		.results_seen (results_seen),
		.covered_seen (covered_seen)
	);

	initial clk = 1'b0;
	always #1 clk = ~clk;

	// idle length: mostly none, some short, a few long; none at all in quiet stretches
	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(0, 99);
		if (quiet || roll < 65)
			return 0;
		if (roll < 93)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [1:0] pick_turn(input int k);
		case (k)
			1: return ROT_QUARTER;
			2: return ROT_HALF;
			3: return ROT_3QUART;
			default: return ROT_NONE;
		endcase
	endfunction

	// screen position back to shape coordinates under the current orientation,
	// used only to aim shapes at chosen screen pixels
	function automatic xy_t to_shape(input int rx, input int ry);
		xy_t s;
		case (orient_cfg)
			ROT_QUARTER: begin
				s.x = ry;
				s.y = width_cfg - rx;
			end
			ROT_HALF: begin
				s.x = width_cfg - rx;
				s.y = height_cfg - ry;
			end
			ROT_3QUART: begin
				s.x = height_cfg - ry;
				s.y = rx;
			end
			default: begin
				s.x = rx;
				s.y = ry;
			end
		endcase
		return s;
	endfunction

	// a coordinate at one of two ends, or anywhere in the span one beyond either end
	function automatic int near_span(input int a, input int b);
		int lo, hi, roll;
		lo = (a < b) ? a : b;
		hi = (a < b) ? b : a;
		roll = $urandom_range(0, 9);
		if (roll < 2)
			return a;
		if (roll < 4)
			return b;
		return lo - 1 + int'($urandom_range(0, hi - lo + 2));
	endfunction

	function automatic pix_item_t random_item();
		pix_item_t it;
		int        u0, u1, u2, r, cx, cy, ex, ey, px, py, dx, dy, kind;
		xy_t       a;
		xy_t       e;
		u0 = $urandom;
		u1 = $urandom;
		u2 = $urandom;
		// start from all fields random, this alone is what one item in ten gets
		it.command  = u0[2*COORD_BITS+1:2*COORD_BITS];
		it.fill     = u0[2*COORD_BITS+2];
		it.anchor_x = u0[COORD_BITS-1:0];
		it.anchor_y = u0[2*COORD_BITS-1:COORD_BITS];
		it.far_x    = u1[COORD_BITS-1:0];
		it.far_y    = u1[2*COORD_BITS-1:COORD_BITS];
		it.in_byte  = u1[31:24];
		it.radius   = u2[RAD_W-1:0];
		it.pixel_x  = u2[RAD_W+PIX_W-1:RAD_W];
		it.pixel_y  = u2[RAD_W+2*PIX_W-1:RAD_W+PIX_W];
		if ($urandom_range(0, 9) == 0)
			return it;

		// aimed item: pick the shape on screen, then a pixel on or next to it
		r  = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 1023) : $urandom_range(0, 40);
		cx = $urandom_range(0, 300);
		cy = $urandom_range(0, 300);
		a  = to_shape(cx, cy);
		px = cx;
		py = cy;
		case (it.command)
			CMD_POINT: begin
				if ($urandom_range(0, 1)) begin
					px = cx - 1 + int'($urandom_range(0, 2));
					py = cy - 1 + int'($urandom_range(0, 2));
				end
			end
			CMD_LINE: begin
				kind = $urandom_range(0, 3);
				ex = $urandom_range(0, 300);
				ey = $urandom_range(0, 300);
				// horizontal, vertical, single pixel, or diagonal
				if (kind == 0)
					ey = cy;
				else if (kind == 1)
					ex = cx;
				else if (kind == 2) begin
					ex = cx;
					ey = cy;
				end
				e = to_shape(ex, ey);
				it.far_x = e.x[COORD_BITS-1:0];
				it.far_y = e.y[COORD_BITS-1:0];
				px = near_span(cx, ex);
				py = near_span(cy, ey);
			end
			CMD_RECT: begin
				ex = cx - 40 + int'($urandom_range(0, 80));
				ey = cy - 40 + int'($urandom_range(0, 80));
				e = to_shape(ex, ey);
				it.far_x = (e.x - a.x) & ((1 << COORD_BITS) - 1);
				it.far_y = (e.y - a.y) & ((1 << COORD_BITS) - 1);
				px = near_span(cx, ex);
				py = near_span(cy, ey);
			end
			default: begin
				dx = -(r + 2) + int'($urandom_range(0, 2 * r + 4));
				if (!it.fill && $urandom_range(0, 1) && dx * dx <= r * r) begin
					// land on the ring itself
					dy = $rtoi($sqrt(real'(r * r - dx * dx)) + 0.5);
					if ($urandom_range(0, 1))
						dy = -dy;
				end else begin
					dy = -(r + 2) + int'($urandom_range(0, 2 * r + 4));
				end
				px = cx + dx;
				py = cy + dy;
			end
		endcase
		if (px < 0)
			px = -px;
		if (py < 0)
			py = -py;
		if (px > 2047)
			px = 2047;
		if (py > 2047)
			py = 2047;
		it.radius   = r[RAD_W-1:0];
		it.anchor_x = a.x[COORD_BITS-1:0];
		it.anchor_y = a.y[COORD_BITS-1:0];
		it.pixel_x  = px[PIX_W-1:0];
		it.pixel_y  = py[PIX_W-1:0];
		return it;
	endfunction

	// one pixel transfer; eager skips the idle gap after it
	task automatic send_pix(input pix_item_t it, input bit eager);
		int g;
		pix       <= it;
		pix_valid <= 1'b1;
		do
			@(posedge clk);
		while (!pix_ready);
		@(negedge clk);
		n_sent++;
		if (!eager) begin
			g = pick_gap();
			if (g > 0) begin
				pix_valid <= 1'b0;
				repeat (g) @(negedge clk);
			end
		end
	endtask

	// directed item from plain integers
	task automatic aim(input logic [1:0] cmd, input bit fill, input int ax, input int ay,
		input int fx, input int fy, input int r, input int px, input int py, input int b);
		pix_item_t it;
		it.command  = cmd;
		it.fill     = fill;
		it.anchor_x = ax[COORD_BITS-1:0];
		it.anchor_y = ay[COORD_BITS-1:0];
		it.far_x    = fx[COORD_BITS-1:0];
		it.far_y    = fy[COORD_BITS-1:0];
		it.radius   = r[RAD_W-1:0];
		it.pixel_x  = px[PIX_W-1:0];
		it.pixel_y  = py[PIX_W-1:0];
		it.in_byte  = b[7:0];
		send_pix(it, 1'b0);
	endtask

	// register write transfer; valid stays up for back-to-back writes
	task automatic write_reg(input logic [1:0] idx, input logic [DIM_W-1:0] data);
		cfg_index <= idx;
		cfg_data  <= data;
		cfg_valid <= 1'b1;
		do
			@(posedge clk);
		while (!cfg_ready);
		@(negedge clk);
	endtask

	task automatic set_display(input logic [1:0] orient, input int w, input int h,
		input bit spare);
		int u;
		u = $urandom;
		if (spare)
			write_reg(CFG_SPARE, u[DIM_W-1:0]);
		// junk above the two orientation bits must be dropped
		write_reg(CFG_ORIENTATION, {u[DIM_W-1:2], orient});
		write_reg(CFG_DISP_WIDTH, w[DIM_W-1:0]);
		write_reg(CFG_DISP_HEIGHT, h[DIM_W-1:0]);
		cfg_valid  <= 1'b0;
		orient_cfg  = orient;
		width_cfg   = w;
		height_cfg  = h;
		settings_run++;
	endtask

	// stop offering and wait for every predicted result to come back
	task automatic drain();
		pix_valid <= 1'b0;
		while (pending != 0)
			@(negedge clk);
	endtask

	// result side: random stalls, plus one long hold-off on request
	initial begin
		int stall_left;
		int hold_left;
		stall_left = 0;
		hold_left  = 0;
		res_ready  = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_left = HOLD_CYCLES;
				hold_req  = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				res_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				res_ready <= 1'b0;
			end else begin
				res_ready <= 1'b1;
				stall_left = pick_gap();
			end
		end
	end

	// watchdog: any transfer on any channel restarts the count
	initial begin
		int idle_cycles;
		idle_cycles = 0;
		while (idle_cycles < STALL_LIMIT) begin
			@(posedge clk);
			if ((pix_valid && pix_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
		end
		$display("no transfer for %0d cycles, %0d results outstanding", STALL_LIMIT, pending);
		$display("** shape_pixel_coverage_top: FAILED **");
		$finish;
	end

	initial begin
		int         phase;
		int         k;
		int         w;
		int         h;
		logic [1:0] orient;
		arst_n       = 1'b0;
		pix_valid    = 1'b0;
		pix          = '0;
		cfg_valid    = 1'b0;
		cfg_index    = CFG_ORIENTATION;
		cfg_data     = '0;
		quiet        = 1'b0;
		hold_req     = 1'b0;
		n_sent       = 0;
		settings_run = 1;
		orient_cfg   = ORIENT_RST;
		width_cfg    = WIDTH_RST;
		height_cfg   = HEIGHT_RST;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed part under the reset display settings
		// points: hit, miss with fill set, field extremes, far right column
		aim(CMD_POINT,  1'b0, 5, 7, 0, 0, 0, 5, 7, 8'hFF);
		aim(CMD_POINT,  1'b1, 5, 7, 0, 0, 0, 6, 7, 8'hFF);
		aim(CMD_POINT,  1'b1, -2048, 2047, 2047, -2048, 1023, 2047, 2047, 8'h00);
		aim(CMD_POINT,  1'b0, 2047, 0, 0, 0, 0, 2047, 0, 8'hFF);
		// lines: horizontal both ways, vertical, just past the end, diagonal, one pixel
		aim(CMD_LINE,   1'b1, 10, 20, 30, 20, 0, 15, 20, 8'hFF);
		aim(CMD_LINE,   1'b0, 30, 20, 10, 20, 0, 10, 20, 8'hAA);
		aim(CMD_LINE,   1'b0, 40, 50, 40, 5, 0, 40, 5, 8'hFF);
		aim(CMD_LINE,   1'b0, 40, 50, 40, 5, 0, 40, 51, 8'hFF);
		aim(CMD_LINE,   1'b0, 0, 0, 10, 10, 0, 0, 0, 8'hFF);
		aim(CMD_LINE,   1'b0, 3, 3, 3, 3, 0, 3, 3, 8'hFF);
		// rectangles: filled inside, edge, hollow middle, negative size, just outside
		aim(CMD_RECT,   1'b1, 100, 50, 20, 10, 0, 110, 55, 8'hFF);
		aim(CMD_RECT,   1'b0, 100, 50, 20, 10, 0, 120, 55, 8'hFF);
		aim(CMD_RECT,   1'b0, 100, 50, 20, 10, 0, 110, 55, 8'hFF);
		aim(CMD_RECT,   1'b0, 100, 50, -20, -10, 0, 80, 45, 8'h55);
		aim(CMD_RECT,   1'b1, 100, 50, 20, 10, 0, 121, 55, 8'hFF);
		// circles: filled, ring, inside the ring, zero radius both kinds, past r+1
		aim(CMD_CIRCLE, 1'b1, 200, 100, 0, 0, 10, 207, 107, 8'hFF);
		aim(CMD_CIRCLE, 1'b0, 200, 100, 0, 0, 10, 210, 100, 8'hFF);
		aim(CMD_CIRCLE, 1'b0, 200, 100, 0, 0, 10, 205, 100, 8'hFF);
		aim(CMD_CIRCLE, 1'b0, 200, 100, 0, 0, 0, 200, 100, 8'hFF);
		aim(CMD_CIRCLE, 1'b0, 200, 100, 0, 0, 0, 201, 100, 8'hFF);
		aim(CMD_CIRCLE, 1'b1, 200, 100, 0, 0, 0, 200, 100, 8'hFF);
		aim(CMD_CIRCLE, 1'b0, 200, 100, 0, 0, 10, 212, 100, 8'hFF);
		// largest radius, ring at the far edge and one past it
		aim(CMD_CIRCLE, 1'b0, 0, 0, 0, 0, 1023, 1023, 0, 8'hFF);
		aim(CMD_CIRCLE, 1'b0, 0, 0, 0, 0, 1023, 1024, 0, 8'hFF);
		// centre off screen
		aim(CMD_CIRCLE, 1'b1, -3, -3, 0, 0, 5, 0, 0, 8'hFF);
		drain();

		// random phases, each under its own display setting
		for (phase = 0; phase < NUM_PHASES; phase++) begin
			orient = pick_turn($urandom_range(0, 3));
			w = 296;
			h = 128;
			case (phase)
				0, 1, 2, 3: orient = pick_turn(phase);
				4: begin
					w = 2047;
					h = 2047;
				end
				5: begin
					w = 1;
					h = 1;
				end
				// zero size is taken as is
				6: begin
					w = 0;
					h = 0;
				end
				default: begin
					w = $urandom_range(1, 2047);
					h = $urandom_range(1, 2047);
				end
			endcase
			set_display(orient, w, h, phase == 6);
			// back pressure phase: receiver holds off while the sender keeps going
			if (phase == 3)
				hold_req = 1'b1;
			// last phase runs with no idling on either side
			quiet = (phase == NUM_PHASES - 1);
			for (k = 0; k < PHASE_ITEMS; k++)
				send_pix(random_item(), phase == 3 && k < 40);
			drain();
		end
		quiet = 1'b0;

		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("covered %0d pixel transfers under %0d display settings, all four turns",
			n_sent, settings_run);
		$display("%0d results checked, %0d of them covered, %0d errors",
			results_seen, covered_seen, errors);
		if (errors == 0 && pending == 0)
			$display("** shape_pixel_coverage_top: PASSED **");
		else
			$display("** shape_pixel_coverage_top: FAILED **");
		$finish;
	end

endmodule
